[rtl/touch_gesture_to_mouse_unit_assert.svh]
// assertion macros for the touch gesture to mouse unit
// used by the top level only; empty bodies when SYNTHESIS is defined
`ifndef TOUCH_GESTURE_TO_MOUSE_UNIT_ASSERT_SVH
`define TOUCH_GESTURE_TO_MOUSE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TGM_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("tgm assertion failed");
`define TGM_ASSERT_NXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("tgm assertion failed");
`else
`define TGM_ASSERT_IMP(label, clk, rstn, a, b)
`define TGM_ASSERT_NXT(label, clk, rstn, a, b)
`endif
`endif

[rtl/tgm_pkg.sv]
// shared types and constants for the touch gesture to mouse unit
// no dependencies
package tgm_pkg;
    localparam int COORD_MAX = 15;
    localparam int PROD_BITS = COORD_MAX + 8;

    typedef enum logic [2:0] {
        K_MOVE     = 3'd0,
        K_SCROLL   = 3'd1,
        K_LPRESS   = 3'd2,
        K_LRELEASE = 3'd3,
        K_LCLICK   = 3'd4,
        K_RCLICK   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        R_DEADBAND    = 3'd0,
        R_X_GAIN      = 3'd1,
        R_Y_GAIN      = 3'd2,
        R_SCROLL_GAIN = 3'd3,
        R_TAP_MAX_MS  = 3'd4,
        R_DTAP_WIN    = 3'd5,
        R_TAP_MOVE    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]  deadband;
        logic [7:0]  x_gain;
        logic [7:0]  y_gain;
        logic [7:0]  scroll_gain;
        logic [15:0] tap_max_ms;
        logic [15:0] dtap_win_ms;
        logic [11:0] tap_max_move;
    } cfg_t;

    typedef struct packed {
        kind_t                kind;
        logic [COORD_MAX-1:0] mag_a;
        logic                 neg_a;
        logic [COORD_MAX-1:0] mag_b;
        logic                 neg_b;
    } job_t;
endpackage

[rtl/tgm_front.sv]
// front part: gesture state tracking and classification of each item
// depends on tgm_pkg; produces jobs for the back part
module tgm_front import tgm_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  in_fire,
    input  logic                  action,
    input  logic                  two_contacts,
    input  logic [COORD_BITS-1:0] x_pos,
    input  logic [COORD_BITS-1:0] y_pos,
    input  logic [COORD_BITS-1:0] y2_pos,
    input  logic [31:0]           time_ms,
    output logic                  job_push,
    output job_t                  job
);
    localparam int DW = COORD_BITS + 1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DRAG = 2'd2
    } phase_t;

    logic one_reg, one_next, two_reg, two_next;
    logic moved_reg, moved_next, cand_reg, cand_next;
    phase_t phase_reg, phase_next;
    logic [COORD_BITS-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [COORD_BITS-1:0] last_y2_reg, last_y2_next, start_x_reg, start_x_next;
    logic [COORD_BITS-1:0] start_y_reg, start_y_next;
    logic [31:0] start_t_reg, start_t_next, tap_t_reg, tap_t_next;
    logic [31:0] pair_t_reg, pair_t_next;

    logic signed [DW-1:0] dx, dy, dy2, sx, sy, dxm, dym, avg;
    logic signed [DW:0]   sum;
    logic [COORD_BITS-1:0] adx, ady, asx, asy, aavg, adxm, adym;
    logic [31:0] dt_start, dt_pair, dt_tap;
    logic [9:0]  thr;
    logic        push;
    job_t        j;

    always_comb begin
        dx  = DW'($signed({1'b0, x_pos})) - DW'($signed({1'b0, last_x_reg}));
        dy  = DW'($signed({1'b0, y_pos})) - DW'($signed({1'b0, last_y_reg}));
        dy2 = DW'($signed({1'b0, y2_pos})) - DW'($signed({1'b0, last_y2_reg}));
        sx  = DW'($signed({1'b0, x_pos})) - DW'($signed({1'b0, start_x_reg}));
        sy  = DW'($signed({1'b0, y_pos})) - DW'($signed({1'b0, start_y_reg}));
        sum = (DW+1)'(dy) + (DW+1)'(dy2);
        avg = DW'((sum + (DW+1)'($signed({1'b0, sum[DW]}))) >>> 1);
        adx  = dx[DW-1]  ? COORD_BITS'(-dx)  : COORD_BITS'(dx);
        ady  = dy[DW-1]  ? COORD_BITS'(-dy)  : COORD_BITS'(dy);
        asx  = sx[DW-1]  ? COORD_BITS'(-sx)  : COORD_BITS'(sx);
        asy  = sy[DW-1]  ? COORD_BITS'(-sy)  : COORD_BITS'(sy);
        aavg = avg[DW-1] ? COORD_BITS'(-avg) : COORD_BITS'(avg);
        dxm  = (16'(adx) < 16'(cfg.deadband)) ? '0 : dx;
        dym  = (16'(ady) < 16'(cfg.deadband)) ? '0 : dy;
        adxm = dxm[DW-1] ? COORD_BITS'(-dxm) : COORD_BITS'(dxm);
        adym = dym[DW-1] ? COORD_BITS'(-dym) : COORD_BITS'(dym);
        thr  = 10'(cfg.deadband) * 10'd3;
        dt_start = time_ms - start_t_reg;
        dt_pair  = time_ms - pair_t_reg;
        dt_tap   = time_ms - tap_t_reg;

        one_next = one_reg;
        two_next = two_reg;
        moved_next = moved_reg;
        cand_next = cand_reg;
        phase_next = phase_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        last_y2_next = last_y2_reg;
        start_x_next = start_x_reg;
        start_y_next = start_y_reg;
        start_t_next = start_t_reg;
        tap_t_next = tap_t_reg;
        pair_t_next = pair_t_reg;
        push = 1'b0;
        j = '0;
        j.kind = K_MOVE;

        if (action) begin
            if (two_reg) begin
                if (cand_reg) begin
                    if (dt_pair < 32'(cfg.tap_max_ms)) begin
                        push = 1'b1;
                        j.kind = K_RCLICK;
                    end
                    cand_next = 1'b0;
                end
            end else if (one_reg) begin
                if (phase_reg == PH_DRAG) begin
                    phase_next = PH_IDLE;
                    push = 1'b1;
                    j.kind = K_LRELEASE;
                end else if (dt_start < 32'(cfg.tap_max_ms) && !moved_reg) begin
                    if (phase_reg == PH_IDLE) begin
                        phase_next = PH_WAIT;
                        tap_t_next = time_ms;
                        push = 1'b1;
                        j.kind = K_LCLICK;
                    end else if (phase_reg == PH_WAIT) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            one_next = 1'b0;
            two_next = 1'b0;
        end else if (two_contacts) begin
            if (!two_reg) begin
                last_x_next = x_pos;
                last_y_next = y_pos;
                last_y2_next = y2_pos;
                two_next = 1'b1;
                one_next = 1'b0;
                pair_t_next = time_ms;
                cand_next = 1'b1;
            end else begin
                if (16'(aavg) >= 16'(thr)) begin
                    cand_next = 1'b0;
                    push = 1'b1;
                    j.kind = K_SCROLL;
                    j.mag_a = COORD_MAX'(aavg);
                    j.neg_a = avg[DW-1];
                    last_y_next = y_pos;
                    last_y2_next = y2_pos;
                end
                last_x_next = x_pos;
            end
        end else begin
            two_next = 1'b0;
            if (!one_reg || two_reg) begin
                last_x_next = x_pos;
                last_y_next = y_pos;
                one_next = 1'b1;
                start_t_next = time_ms;
                start_x_next = x_pos;
                start_y_next = y_pos;
                moved_next = 1'b0;
                if (phase_reg == PH_WAIT) begin
                    if (dt_tap < 32'(cfg.dtap_win_ms)) begin
                        phase_next = PH_DRAG;
                        push = 1'b1;
                        j.kind = K_LPRESS;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
            end else begin
                if (16'(asx) > 16'(cfg.tap_max_move) ||
                    16'(asy) > 16'(cfg.tap_max_move)) begin
                    moved_next = 1'b1;
                    if (phase_reg == PH_WAIT) begin
                        phase_next = PH_IDLE;
                    end
                end
                if (adxm != '0 || adym != '0) begin
                    push = 1'b1;
                    j.kind = K_MOVE;
                    j.mag_a = COORD_MAX'(adxm);
                    j.neg_a = dxm[DW-1];
                    j.mag_b = COORD_MAX'(adym);
                    j.neg_b = !dym[DW-1];
                    last_x_next = x_pos;
                    last_y_next = y_pos;
                end
            end
        end
    end

    assign job_push = in_fire && push;
    assign job = j;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_reg <= 1'b0;
            two_reg <= 1'b0;
            moved_reg <= 1'b0;
            cand_reg <= 1'b0;
            phase_reg <= PH_IDLE;
            last_x_reg <= '0;
            last_y_reg <= '0;
            last_y2_reg <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_t_reg <= '0;
            tap_t_reg <= '0;
            pair_t_reg <= '0;
        end else if (in_fire) begin
            one_reg <= one_next;
            two_reg <= two_next;
            moved_reg <= moved_next;
            cand_reg <= cand_next;
            phase_reg <= phase_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            last_y2_reg <= last_y2_next;
            start_x_reg <= start_x_next;
            start_y_reg <= start_y_next;
            start_t_reg <= start_t_next;
            tap_t_reg <= tap_t_next;
            pair_t_reg <= pair_t_next;
        end
    end
endmodule

[rtl/tgm_queue.sv]
// two-entry job queue between front and back parts
// depends on tgm_pkg for the job type
module tgm_queue import tgm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output job_t q_job
);
    job_t       ent_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job = ent_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule

[rtl/tgm_back.sv]
// back part: gain multiply, divide by ten, saturation and result register
// depends on tgm_pkg
module tgm_back import tgm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  job_t        q_job,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_report_kind,
    output logic [7:0]  m_move_x,
    output logic [7:0]  m_move_y,
    output logic [7:0]  m_wheel
);
    logic                 a_valid_reg;
    kind_t                a_kind_reg;
    logic [PROD_BITS-1:0] a_prod_reg, b_prod_reg;
    logic                 a_neg_reg, b_neg_reg;
    logic [7:0]           ga;
    logic [7:0]           res_a, res_b;
    logic                 out_free, a_adv, drop;
    logic                 m_valid_reg;
    logic [2:0]           kind_reg;
    logic [7:0]           mx_reg, my_reg, wh_reg;

    function automatic logic [7:0] scale(input logic [PROD_BITS-1:0] p, input logic neg);
        logic [23:0] q;
        logic [6:0]  m;
        q = 24'(p[10:0]) * 24'd6554;
        m = (p >= PROD_BITS'(1270)) ? 7'd127 : q[22:16];
        return neg ? 8'(-{1'b0, m}) : {1'b0, m};
    endfunction

    assign ga = (q_job.kind == K_SCROLL) ? cfg.scroll_gain : cfg.x_gain;
    assign res_a = scale(a_prod_reg, a_neg_reg);
    assign res_b = scale(b_prod_reg, b_neg_reg);
    assign drop = (a_kind_reg == K_SCROLL) && (res_a == 8'd0);
    assign out_free = !m_valid_reg || m_ready;
    assign a_adv = a_valid_reg && out_free;
    assign pop = q_valid && (!a_valid_reg || out_free);

    always_ff @(posedge aclk) begin
        if (pop) begin
            a_kind_reg <= q_job.kind;
            a_prod_reg <= PROD_BITS'(q_job.mag_a) * PROD_BITS'(ga);
            b_prod_reg <= PROD_BITS'(q_job.mag_b) * PROD_BITS'(cfg.y_gain);
            a_neg_reg <= q_job.neg_a;
            b_neg_reg <= q_job.neg_b;
        end
        if (a_adv && !drop) begin
            kind_reg <= a_kind_reg;
            mx_reg <= (a_kind_reg == K_MOVE) ? res_a : 8'd0;
            my_reg <= (a_kind_reg == K_MOVE) ? res_b : 8'd0;
            wh_reg <= (a_kind_reg == K_SCROLL) ? res_a : 8'd0;
        end
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= a_valid_reg && !drop;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_report_kind = kind_reg;
    assign m_move_x = mx_reg;
    assign m_move_y = my_reg;
    assign m_wheel = wh_reg;
endmodule

[rtl/touch_gesture_to_mouse_unit.sv]
// Touchpad gesture to mouse report unit. Takes one touch item per clock cycle
// when the job queue has room; each item yields zero or one mouse report. Gesture
// state is updated in the cycle an item is accepted, so items follow back to back.
// When the result side does not stall, a report follows its item in order: the job enters
// the two-entry queue at the edge that accepts the item, then the gain product is
// registered, and then the result register is loaded and the report becomes valid.
// Throughput is set by the front state update, one item per cycle; a stalled result
// side fills the queue and holds s_ready low. Configuration is written through cfg_we.
// depends on tgm_pkg, tgm_front, tgm_queue, tgm_back and the assertion header
`include "touch_gesture_to_mouse_unit_assert.svh"
module touch_gesture_to_mouse_unit import tgm_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic                  s_two_contacts,
    input  logic [COORD_BITS-1:0] s_x_pos,
    input  logic [COORD_BITS-1:0] s_y_pos,
    input  logic [COORD_BITS-1:0] s_x2_pos,
    input  logic [COORD_BITS-1:0] s_y2_pos,
    input  logic [31:0]           s_time_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_report_kind,
    output logic signed [7:0]     m_move_x,
    output logic signed [7:0]     m_move_y,
    output logic signed [7:0]     m_wheel
);
    cfg_t cfg_reg;
    logic q_full, q_valid, pop, job_push, in_fire;
    job_t job, q_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadband <= 8'd2;
            cfg_reg.x_gain <= 8'd10;
            cfg_reg.y_gain <= 8'd10;
            cfg_reg.scroll_gain <= 8'd10;
            cfg_reg.tap_max_ms <= 16'd200;
            cfg_reg.dtap_win_ms <= 16'd300;
            cfg_reg.tap_max_move <= 12'd20;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                R_DEADBAND:    cfg_reg.deadband <= cfg_wdata[7:0];
                R_X_GAIN:      cfg_reg.x_gain <= cfg_wdata[7:0];
                R_Y_GAIN:      cfg_reg.y_gain <= cfg_wdata[7:0];
                R_SCROLL_GAIN: cfg_reg.scroll_gain <= cfg_wdata[7:0];
                R_TAP_MAX_MS:  cfg_reg.tap_max_ms <= cfg_wdata;
                R_DTAP_WIN:    cfg_reg.dtap_win_ms <= cfg_wdata;
                R_TAP_MOVE:    cfg_reg.tap_max_move <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    tgm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .in_fire(in_fire),
        .action(s_action), .two_contacts(s_two_contacts), .x_pos(s_x_pos),
        .y_pos(s_y_pos), .y2_pos(s_y2_pos), .time_ms(s_time_ms),
        .job_push(job_push), .job(job)
    );

    tgm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(job_push), .push_job(job),
        .full(q_full), .pop(pop), .q_valid(q_valid), .q_job(q_job)
    );

    tgm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_valid(q_valid),
        .q_job(q_job), .pop(pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_report_kind(m_report_kind), .m_move_x(m_move_x), .m_move_y(m_move_y),
        .m_wheel(m_wheel)
    );

    `TGM_ASSERT_IMP(a_move_only, aclk, aresetn, m_valid && m_report_kind != K_MOVE, m_move_x == 8'sd0 && m_move_y == 8'sd0)
    `TGM_ASSERT_IMP(a_scroll_nonzero, aclk, aresetn, m_valid && m_report_kind == K_SCROLL, m_wheel != 8'sd0)
    `TGM_ASSERT_IMP(a_full_has_items, aclk, aresetn, !s_ready, q_valid)
endmodule

[bench/tb_touch_gesture_to_mouse_unit.sv]
// self-checking bench for touch_gesture_to_mouse_unit: gesture items in, mouse reports out
// expected reports come from a behavioral gesture tracker inside this file
// depends on tgm_pkg and the unit's rtl
module tb_touch_gesture_to_mouse_unit;
    import tgm_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  mx;
        logic [7:0]  my;
        logic [7:0]  wh;
    } report_t;

    typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_WAIT = 2'd1, PH_DRAG = 2'd2} phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic        s_two_contacts = 1'b0;
    logic [11:0] s_x_pos = '0, s_y_pos = '0, s_x2_pos = '0, s_y2_pos = '0;
    logic [31:0] s_time_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_report_kind;
    logic signed [7:0] m_move_x, m_move_y, m_wheel;

    touch_gesture_to_mouse_unit i_dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tracker configuration and state
    int unsigned c_deadband, c_x_gain, c_y_gain, c_scroll_gain;
    int unsigned c_tap_ms, c_dtap_ms, c_tap_move;
    bit one_trk, two_trk, moved, pair_cand;
    int p_last_x, p_last_y, p_last_y2, p_start_x, p_start_y;
    logic [31:0] p_start_t, p_tap_t, p_pair_t;
    phase_t phase;

    report_t expected_reports[$];
    int errors = 0;
    int n_reports = 0;
    int n_items = 0;
    int ready_hold = 0;
    bit calm = 1'b0;
    logic [31:0] clock_ms = 32'd1000;

    function automatic int sat127(int v);
        if (v > 127) return 127;
        if (v < -127) return -127;
        return v;
    endfunction

    function automatic int absval(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void push_report(logic [2:0] k, int mx, int my, int wh);
        report_t r;
        r.kind = k;
        r.mx = mx[7:0];
        r.my = my[7:0];
        r.wh = wh[7:0];
        expected_reports.push_back(r);
    endfunction

    function automatic void track_gesture(bit lift, bit two, int x, int y, int y2,
                                          logic [31:0] now);
        int avg, s, dx, dy;
        if (lift) begin
            if (two_trk) begin
                if (pair_cand) begin
                    if (32'(now - p_pair_t) < c_tap_ms) push_report(K_RCLICK, 0, 0, 0);
                    pair_cand = 0;
                end
            end else if (one_trk) begin
                if (phase == PH_DRAG) begin
                    phase = PH_IDLE;
                    push_report(K_LRELEASE, 0, 0, 0);
                end else if (32'(now - p_start_t) < c_tap_ms && !moved) begin
                    if (phase == PH_IDLE) begin
                        phase = PH_WAIT;
                        p_tap_t = now;
                        push_report(K_LCLICK, 0, 0, 0);
                    end else if (phase == PH_WAIT) begin
                        phase = PH_IDLE;
                    end
                end
            end
            one_trk = 0;
            two_trk = 0;
            return;
        end
        if (two) begin
            if (!two_trk) begin
                p_last_x = x; p_last_y = y; p_last_y2 = y2;
                two_trk = 1; one_trk = 0;
                p_pair_t = now; pair_cand = 1;
                return;
            end
            avg = ((y - p_last_y) + (y2 - p_last_y2)) / 2;
            if (absval(avg) >= int'(c_deadband) * 3) begin
                s = sat127(avg * int'(c_scroll_gain) / 10);
                pair_cand = 0;
                if (s != 0) push_report(K_SCROLL, 0, 0, s);
                p_last_y = y; p_last_y2 = y2;
            end
            p_last_x = x;
            return;
        end
        if (two_trk) begin
            two_trk = 0; one_trk = 0;
        end
        if (!one_trk) begin
            p_last_x = x; p_last_y = y;
            one_trk = 1;
            p_start_t = now; p_start_x = x; p_start_y = y;
            moved = 0;
            if (phase == PH_WAIT) begin
                if (32'(now - p_tap_t) < c_dtap_ms) begin
                    phase = PH_DRAG;
                    push_report(K_LPRESS, 0, 0, 0);
                end else begin
                    phase = PH_IDLE;
                end
            end
            return;
        end
        dx = x - p_last_x;
        dy = y - p_last_y;
        if (absval(x - p_start_x) > int'(c_tap_move) ||
            absval(y - p_start_y) > int'(c_tap_move)) begin
            moved = 1;
            if (phase == PH_WAIT) phase = PH_IDLE;
        end
        if (absval(dx) < int'(c_deadband)) dx = 0;
        if (absval(dy) < int'(c_deadband)) dy = 0;
        if (dx != 0 || dy != 0) begin
            push_report(K_MOVE, sat127(dx * int'(c_x_gain) / 10),
                        sat127(-dy * int'(c_y_gain) / 10), 0);
            p_last_x = x; p_last_y = y;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic send_item(bit lift, bit two, logic [11:0] x, logic [11:0] y,
                             logic [11:0] x2, logic [11:0] y2, logic [31:0] t);
        idle_burst();
        s_valid <= 1'b1;
        s_action <= lift;
        s_two_contacts <= two;
        s_x_pos <= x; s_y_pos <= y; s_x2_pos <= x2; s_y2_pos <= y2;
        s_time_ms <= t;
        track_gesture(lift, two, x, y, y2, t);
        n_items++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic contact(int x, int y, int dt);
        clock_ms += dt;
        send_item(1'b0, 1'b0, x, y, 12'($urandom), 12'($urandom), clock_ms);
    endtask

    task automatic pair(int x, int y, int y2, int dt);
        clock_ms += dt;
        send_item(1'b0, 1'b1, x, y, 12'($urandom), y2, clock_ms);
    endtask

    task automatic lift(int dt);
        clock_ms += dt;
        send_item(1'b1, 1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), clock_ms);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[15:0];
        @(posedge aclk);
        case (idx)
            R_DEADBAND:    c_deadband = val & 8'hff;
            R_X_GAIN:      c_x_gain = val & 8'hff;
            R_Y_GAIN:      c_y_gain = val & 8'hff;
            R_SCROLL_GAIN: c_scroll_gain = val & 8'hff;
            R_TAP_MAX_MS:  c_tap_ms = val & 16'hffff;
            R_DTAP_WIN:    c_dtap_ms = val & 16'hffff;
            R_TAP_MOVE:    c_tap_move = val & 12'hfff;
            default: ;
        endcase
    endtask

    task automatic set_config(int mt, int xg, int yg, int sg, int tm, int dw, int mv);
        drain();
        write_reg(R_DEADBAND, mt);
        write_reg(R_X_GAIN, xg);
        write_reg(R_Y_GAIN, yg);
        write_reg(R_SCROLL_GAIN, sg);
        write_reg(R_TAP_MAX_MS, tm);
        write_reg(R_DTAP_WIN, dw);
        write_reg(R_TAP_MOVE, mv);
        cfg_we <= 1'b0;
    endtask

    // result side stalls in random bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            if (ready_hold == 0) m_ready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            ready_hold = $urandom_range(1, 12);
        end
    end

    always @(posedge aclk) begin
        report_t w;
        if (aresetn && m_valid && m_ready) begin
            n_reports++;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected report kind", m_report_kind, -1);
            end else begin
                w = expected_reports.pop_front();
                if (m_report_kind !== w.kind) report_mismatch("kind", m_report_kind, w.kind);
                if (m_move_x !== w.mx) report_mismatch("move_x", m_move_x, $signed(w.mx));
                if (m_move_y !== w.my) report_mismatch("move_y", m_move_y, $signed(w.my));
                if (m_wheel !== w.wh) report_mismatch("wheel", m_wheel, $signed(w.wh));
            end
        end
    end

    task automatic test_directed();
        contact(100, 100, 5);
        lift(50);                   // left click
        contact(102, 101, 100);     // drag start
        contact(4095, 0, 10);       // saturated move
        contact(0, 4095, 10);
        lift(10);                   // release
        contact(10, 10, 10);
        lift(10);                   // click
        contact(10, 10, 10);
        lift(10);                   // second tap starts a drag; this lift releases it
        lift(10);                   // lift while idle
        pair(500, 500, 500, 10);
        lift(50);                   // right click
        pair(500, 500, 500, 10);
        pair(501, 4095, 4095, 10);  // large scroll
        pair(501, 0, 0, 10);
        pair(501, 1, 1, 10);        // below threshold
        contact(300, 300, 10);      // leaves pair tracking
        contact(301, 301, 10);
        lift(400);
        clock_ms = 32'hffff_ff00;   // timestamp wrap
        contact(50, 50, 0);
        lift(512);
        contact(50, 50, 100);
        lift(10);
    endtask

    task automatic test_extreme_config();
        set_config(0, 255, 255, 255, 65535, 65535, 4095);
        pair(0, 0, 0, 1);
        pair(0, 0, 0, 1);           // zero deadband scroll of zero
        pair(0, 3, 3, 1);
        contact(0, 0, 1);
        contact(1, 4095, 1);
        lift(1);
        set_config(255, 0, 0, 0, 0, 0, 0);
        contact(0, 0, 1);
        contact(4095, 4095, 1);
        lift(0);
        pair(0, 0, 0, 1);
        pair(0, 4095, 4095, 1);
        lift(1);
    endtask

    task automatic random_gesture();
        int x, y, y2, n;
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        n = $urandom_range(0, 6);
        case ($urandom_range(0, 5))
            0, 1: begin
                contact(x, y, $urandom_range(1, 300));
                for (int i = 0; i < n; i++) begin
                    x = $urandom_range(0, 1) ? x + $urandom_range(0, 60) - 30
                                             : $urandom_range(0, 4095);
                    y = y + $urandom_range(0, 60) - 30;
                    contact(x & 12'hfff, y & 12'hfff, $urandom_range(0, 60));
                end
                lift($urandom_range(0, 300));
            end
            2: begin
                contact(x, y, $urandom_range(1, 400));
                if ($urandom_range(0, 1)) contact(x + 1 & 12'hfff, y, $urandom_range(0, 90));
                lift($urandom_range(0, 250));
            end
            3: begin
                y2 = $urandom_range(0, 4095);
                pair(x, y, y2, $urandom_range(1, 300));
                for (int i = 0; i < n; i++) begin
                    y = (y + $urandom_range(0, 200) - 100) & 12'hfff;
                    y2 = (y2 + $urandom_range(0, 200) - 100) & 12'hfff;
                    pair(x, y, y2, $urandom_range(0, 80));
                end
                if ($urandom_range(0, 3) == 0) contact(x, y, 5);
                lift($urandom_range(0, 300));
            end
            default: begin
                clock_ms += $urandom;
                send_item(1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
                          12'($urandom), 12'($urandom), clock_ms);
            end
        endcase
    endtask

    task automatic test_random(int items);
        int goal;
        goal = n_items + items;
        while (n_items < goal) random_gesture();
    endtask

    initial begin
        c_deadband = 2; c_x_gain = 10; c_y_gain = 10; c_scroll_gain = 10;
        c_tap_ms = 200; c_dtap_ms = 300; c_tap_move = 20;
        phase = PH_IDLE;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extreme_config();
        set_config(2, 10, 10, 10, 200, 300, 20);
        test_random(500);
        drain();                    // full pause before changing gains
        set_config(1, 37, 200, 3, 150, 1000, 8);
        test_random(400);
        set_config(5, 12, 7, 25, 300, 200, 40);
        test_random(300);
        calm = 1'b1;
        test_random(150);
        drain();
        $display("covered %0d items and %0d reports: taps, drags, right clicks, moves,",
                 n_items, n_reports);
        $display("scrolls, time wrap and extreme register settings");
        if (errors == 0) begin
            $display("touch_gesture_to_mouse_unit: match");
        end else begin
            $display("touch_gesture_to_mouse_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("touch_gesture_to_mouse_unit: mismatch");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/tgm_pkg.sv
rtl/tgm_front.sv
rtl/tgm_queue.sv
rtl/tgm_back.sv
rtl/touch_gesture_to_mouse_unit.sv
bench/tb_touch_gesture_to_mouse_unit.sv
